FILE: hw/rtl/ksm_pkg.sv
`timescale 1ns / 1ps

package ksm_pkg;

   localparam int MAX_STREAMS_DEF = 16;
   localparam int VALUE_BITS_DEF  = 32;
   localparam int STREAM_BITS     = 4;
   localparam int OPCODE_BITS     = 2;
   localparam int KIND_BITS       = 2;
   localparam int WORD_BITS       = 32;
   localparam int COUNT_REG_BITS  = 5;
   localparam int ADDR_BITS       = 3;

   localparam logic [0:0] CSR_STREAMS_IN_USE = 1'b0;
   localparam logic [COUNT_REG_BITS-1:0] STREAMS_IN_USE_RESET = 5'd2;

   typedef enum logic [OPCODE_BITS-1:0] {
      OP_OFFER   = 2'd0,
      OP_EXHAUST = 2'd1,
      OP_START   = 2'd2
   } opcode_type;

   typedef enum logic [KIND_BITS-1:0] {
      KIND_ELEM = 2'd0,
      KIND_DONE = 2'd1,
      KIND_ERR  = 2'd2
   } kind_type;

   typedef enum logic {
      ST_IDLE,
      ST_POP
   } state_type;

   // one command to every cell of the sorted chain
   typedef struct packed {
      logic clear;
      logic insert;
      logic pop;
   } chain_ctrl_type;

endpackage

FILE: hw/rtl/ksm_cell.sv
`timescale 1ns / 1ps

module ksm_cell #(
   parameter int VALUE_BITS = ksm_pkg::VALUE_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  ksm_pkg::chain_ctrl_type          ctrl,
   input  logic signed [VALUE_BITS-1:0]     new_value,
   input  logic [ksm_pkg::STREAM_BITS-1:0]  new_stream,
   input  logic                             left_valid,
   input  logic [ksm_pkg::STREAM_BITS-1:0]  left_stream,
   input  logic signed [VALUE_BITS-1:0]     left_value,
   input  logic                             left_new_lt,
   input  logic                             right_valid,
   input  logic [ksm_pkg::STREAM_BITS-1:0]  right_stream,
   input  logic signed [VALUE_BITS-1:0]     right_value,
   output logic                             cell_valid,
   output logic [ksm_pkg::STREAM_BITS-1:0]  cell_stream,
   output logic signed [VALUE_BITS-1:0]     cell_value,
   output logic                             new_lt
);
   import ksm_pkg::*;

   logic                         valid_ff, valid_in;
   logic [STREAM_BITS-1:0]       stream_ff, stream_in;
   logic signed [VALUE_BITS-1:0] value_ff, value_in;

   // new word sorts ahead of this cell; ties on value go to the lower stream
   assign new_lt = !valid_ff || (new_value < value_ff) ||
                   ((new_value == value_ff) && (new_stream < stream_ff));

   always_comb begin
      valid_in  = valid_ff;
      stream_in = stream_ff;
      value_in  = value_ff;
      if (ctrl.clear) begin
         valid_in = 1'b0;
      end else if (ctrl.pop) begin
         valid_in  = right_valid;
         stream_in = right_stream;
         value_in  = right_value;
      end else if (ctrl.insert && new_lt) begin
         if (left_new_lt) begin
            // shift the left neighbor in
            valid_in  = left_valid;
            stream_in = left_stream;
            value_in  = left_value;
         end else begin
            valid_in  = 1'b1;
            stream_in = new_stream;
            value_in  = new_value;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      stream_ff <= stream_in;
      value_ff  <= value_in;
   end

   assign cell_valid  = valid_ff;
   assign cell_stream = stream_ff;
   assign cell_value  = value_ff;

endmodule

FILE: hw/rtl/ksm_chain.sv
`timescale 1ns / 1ps

module ksm_chain #(
   parameter int MAX_STREAMS = ksm_pkg::MAX_STREAMS_DEF,
   parameter int VALUE_BITS  = ksm_pkg::VALUE_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  ksm_pkg::chain_ctrl_type          ctrl,
   input  logic signed [VALUE_BITS-1:0]     new_value,
   input  logic [ksm_pkg::STREAM_BITS-1:0]  new_stream,
   output logic                             head_valid,
   output logic [ksm_pkg::STREAM_BITS-1:0]  head_stream,
   output logic signed [VALUE_BITS-1:0]     head_value
);
   import ksm_pkg::*;

   logic                         c_valid  [MAX_STREAMS];
   logic [STREAM_BITS-1:0]       c_stream [MAX_STREAMS];
   logic signed [VALUE_BITS-1:0] c_value  [MAX_STREAMS];
   logic                         c_new_lt [MAX_STREAMS];

   for (genvar i = 0; i < MAX_STREAMS; i++) begin : g_cell
      logic                         l_valid, r_valid, l_new_lt;
      logic [STREAM_BITS-1:0]       l_stream, r_stream;
      logic signed [VALUE_BITS-1:0] l_value, r_value;

      if (i == 0) begin : g_first
         assign l_valid  = 1'b0;
         assign l_stream = '0;
         assign l_value  = '0;
         assign l_new_lt = 1'b0;
      end else begin : g_left
         assign l_valid  = c_valid[i-1];
         assign l_stream = c_stream[i-1];
         assign l_value  = c_value[i-1];
         assign l_new_lt = c_new_lt[i-1];
      end

      if (i == MAX_STREAMS - 1) begin : g_last
         assign r_valid  = 1'b0;
         assign r_stream = '0;
         assign r_value  = '0;
      end else begin : g_right
         assign r_valid  = c_valid[i+1];
         assign r_stream = c_stream[i+1];
         assign r_value  = c_value[i+1];
      end

      ksm_cell #(
         .VALUE_BITS(VALUE_BITS)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .new_value   (new_value),
         .new_stream  (new_stream),
         .left_valid  (l_valid),
         .left_stream (l_stream),
         .left_value  (l_value),
         .left_new_lt (l_new_lt),
         .right_valid (r_valid),
         .right_stream(r_stream),
         .right_value (r_value),
         .cell_valid  (c_valid[i]),
         .cell_stream (c_stream[i]),
         .cell_value  (c_value[i]),
         .new_lt      (c_new_lt[i])
      );
   end

   assign head_valid  = c_valid[0];
   assign head_stream = c_stream[0];
   assign head_value  = c_value[0];

endmodule

FILE: hw/rtl/k_way_sorted_merge.sv
`timescale 1ns / 1ps

// K-way sorted merge. Stream heads sit in a chain of MAX_STREAMS cells kept in
// ascending order (value, then stream number), so the smallest head is always
// in the first cell. A start word clears the chain; fill answers for streams 0
// to streams_in_use-1, clipped to MAX_STREAMS, follow in order, then each
// emitted element is followed by the answer for its stream. A start, error or
// plain fill answer is handled in the idle state; for an answer that leads to
// an emit, every cell compares and shifts in the new head, then the pop state
// moves the first cell into the result register once that register is free.
// Idle, a new word is taken once the result register is empty or draining.
module k_way_sorted_merge #(
   parameter int MAX_STREAMS = ksm_pkg::MAX_STREAMS_DEF,
   parameter int VALUE_BITS  = ksm_pkg::VALUE_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [ksm_pkg::OPCODE_BITS-1:0]     req_opcode,
   input  logic [ksm_pkg::STREAM_BITS-1:0]     req_stream,
   input  logic signed [ksm_pkg::WORD_BITS-1:0] req_value,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [ksm_pkg::KIND_BITS-1:0]       rsp_kind,
   output logic signed [ksm_pkg::WORD_BITS-1:0] rsp_value_out,
   output logic [ksm_pkg::STREAM_BITS-1:0]     rsp_source_stream,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [ksm_pkg::ADDR_BITS-1:0]       paddr,
   input  logic [ksm_pkg::WORD_BITS-1:0]       pwdata,
   output logic [ksm_pkg::WORD_BITS-1:0]       prdata,
   output logic                                pready
);
   import ksm_pkg::*;

   localparam int CNT_BITS = $clog2(MAX_STREAMS + 1);
   localparam int LIM_BITS = (CNT_BITS > COUNT_REG_BITS) ? CNT_BITS : COUNT_REG_BITS;

   state_type                    state_ff, state_in;
   logic [COUNT_REG_BITS-1:0]    siu_ff, siu_in;
   logic [CNT_BITS-1:0]          fill_ff, fill_in;
   logic                         awaiting_ff, awaiting_in;
   logic [STREAM_BITS-1:0]       awaited_ff, awaited_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   kind_type                     rsp_kind_ff, res_kind;
   logic signed [WORD_BITS-1:0]  rsp_value_ff, res_value;
   logic [STREAM_BITS-1:0]       rsp_stream_ff, res_stream;
   logic                         res_load;

   chain_ctrl_type               ctrl;
   logic                         go_pop;
   logic                         head_valid;
   logic [STREAM_BITS-1:0]       head_stream;
   logic signed [VALUE_BITS-1:0] head_value;

   opcode_type                   req_op;
   logic                         out_free, accept;
   logic [LIM_BITS-1:0]          siu_ext, max_ext, lim, fill_ext, fill_inc_ext, stream_ext;
   logic [CNT_BITS-1:0]          fill_inc;
   logic [VALUE_BITS+WORD_BITS-1:0] new_wide, head_wide;
   logic signed [VALUE_BITS-1:0] new_value;
   logic                         csr_write;

   // configuration port
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign siu_in    = (csr_write && paddr[2] == CSR_STREAMS_IN_USE) ?
                      pwdata[COUNT_REG_BITS-1:0] : siu_ff;
   assign prdata    = (paddr[2] == CSR_STREAMS_IN_USE) ?
                      {{(WORD_BITS-COUNT_REG_BITS){1'b0}}, siu_ff} : '0;

   // live stream limit, clipped to the cell count
   assign siu_ext      = LIM_BITS'(siu_ff);
   assign max_ext      = LIM_BITS'(MAX_STREAMS);
   assign lim          = (siu_ext > max_ext) ? max_ext : siu_ext;
   assign fill_inc     = fill_ff + CNT_BITS'(1);
   assign fill_ext     = LIM_BITS'(fill_ff);
   assign fill_inc_ext = LIM_BITS'(fill_inc);
   assign stream_ext   = LIM_BITS'(req_stream);

   assign new_wide  = {{VALUE_BITS{req_value[WORD_BITS-1]}}, req_value};
   assign new_value = new_wide[VALUE_BITS-1:0];
   assign head_wide = {{WORD_BITS{1'b0}}, head_value};

   assign req_op    = opcode_type'(req_opcode);
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) && out_free;
   assign accept    = req_valid && req_ready;

   ksm_chain #(
      .MAX_STREAMS(MAX_STREAMS),
      .VALUE_BITS (VALUE_BITS)
   ) u_chain (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .new_value  (new_value),
      .new_stream (req_stream),
      .head_valid (head_valid),
      .head_stream(head_stream),
      .head_value (head_value)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && go_pop) begin
               state_in = ST_POP;
            end
         end
         ST_POP: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      ctrl        = '0;
      go_pop      = 1'b0;
      res_load    = 1'b0;
      res_kind    = KIND_ERR;
      res_value   = '0;
      res_stream  = '0;
      fill_in     = fill_ff;
      awaiting_in = awaiting_ff;
      awaited_in  = awaited_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_op) inside
                  OP_START: begin
                     ctrl.clear  = 1'b1;
                     fill_in     = '0;
                     awaiting_in = 1'b0;
                     awaited_in  = '0;
                     if (lim == '0) begin
                        res_load = 1'b1;
                        res_kind = KIND_DONE;
                     end
                  end
                  OP_OFFER, OP_EXHAUST: begin
                     if (awaiting_ff) begin
                        if (req_stream != awaited_ff) begin
                           res_load = 1'b1;
                        end else begin
                           ctrl.insert = (req_op == OP_OFFER);
                           go_pop      = 1'b1;
                        end
                     end else if (fill_ext < lim) begin
                        if (stream_ext != fill_ext) begin
                           res_load = 1'b1;
                        end else begin
                           ctrl.insert = (req_op == OP_OFFER);
                           fill_in     = fill_inc;
                           go_pop      = (fill_inc_ext == lim);
                        end
                     end else begin
                        res_load = 1'b1;
                     end
                  end
                  default: res_load = 1'b1;
               endcase
            end
         end
         ST_POP: begin
            if (out_free) begin
               res_load = 1'b1;
               if (head_valid) begin
                  // drop the head and wait for its stream
                  ctrl.pop    = 1'b1;
                  res_kind    = KIND_ELEM;
                  res_value   = head_wide[WORD_BITS-1:0];
                  res_stream  = head_stream;
                  awaiting_in = 1'b1;
                  awaited_in  = head_stream;
               end else begin
                  res_kind    = KIND_DONE;
                  awaiting_in = 1'b0;
                  awaited_in  = '0;
               end
            end
         end
         default: ;
      endcase
   end

   assign rsp_valid_in = res_load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         siu_ff       <= STREAMS_IN_USE_RESET;
         fill_ff      <= '0;
         awaiting_ff  <= 1'b0;
         awaited_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         siu_ff       <= siu_in;
         fill_ff      <= fill_in;
         awaiting_ff  <= awaiting_in;
         awaited_ff   <= awaited_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (res_load) begin
         rsp_kind_ff   <= res_kind;
         rsp_value_ff  <= res_value;
         rsp_stream_ff <= res_stream;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_kind          = rsp_kind_ff;
   assign rsp_value_out     = rsp_value_ff;
   assign rsp_source_stream = rsp_stream_ff;

endmodule

FILE: tb/k_way_sorted_merge_tb.sv
`timescale 1ns / 1ps

module k_way_sorted_merge_tb;
   import ksm_pkg::*;

   localparam logic [OPCODE_BITS-1:0] OP_UNUSED = 2'd3;
   localparam logic [ADDR_BITS-1:0] COUNT_ADDR = ADDR_BITS'(4 * CSR_STREAMS_IN_USE);
   localparam int COUNT_MAX = (1 << COUNT_REG_BITS) - 1;
   localparam longint VALUE_MIN = -64'sd2147483648;
   localparam longint VALUE_MAX = 64'sd2147483647;
   localparam int WORD_BUDGET = 1772;
   localparam int LONG_HOLD = 300;
   localparam int SETTLE_CYCLES = 4;
   localparam int DRAIN_TAIL = 8;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int PRINT_CAP = 40;

   typedef struct {
      kind_type                    kind;
      logic signed [WORD_BITS-1:0] value;
      logic [STREAM_BITS-1:0]      src;
   } merge_word_type;

   // Tracks the merge as the block should see it and holds the words it owes.
   class merge_tracker;
      merge_word_type outputs_due[$];
      int unsigned mismatches;
      logic [COUNT_REG_BITS-1:0] stream_count;
      logic head_valid [MAX_STREAMS_DEF];
      logic signed [WORD_BITS-1:0] head_value [MAX_STREAMS_DEF];
      int fill_progress;
      logic awaiting_refill;
      logic [STREAM_BITS-1:0] awaited_stream;

      function new();
         mismatches = 0;
         stream_count = STREAMS_IN_USE_RESET;
         clear_merge();
      endfunction

      function void clear_merge();
         int i;
         for (i = 0; i < MAX_STREAMS_DEF; i++) begin
            head_valid[i] = 1'b0;
            head_value[i] = '0;
         end
         fill_progress = 0;
         awaiting_refill = 1'b0;
         awaited_stream = '0;
      endfunction

      function int stream_limit();
         return (stream_count > MAX_STREAMS_DEF) ? MAX_STREAMS_DEF : int'(stream_count);
      endfunction

      function void set_stream_count(logic [COUNT_REG_BITS-1:0] count);
         stream_count = count;
      endfunction

      function void push_out(kind_type k, logic signed [WORD_BITS-1:0] val,
                             logic [STREAM_BITS-1:0] src);
         merge_word_type w;
         w.kind = k;
         w.value = val;
         w.src = src;
         outputs_due = {outputs_due, w};
      endfunction

      function void insert_head(logic [STREAM_BITS-1:0] s, logic signed [WORD_BITS-1:0] v);
         if (!head_valid[s]) begin
            head_valid[s] = 1'b1;
            head_value[s] = v;
         end
      endfunction

      // strict less keeps the lower stream first on equal values
      function void emit_smallest();
         int i, best;
         best = -1;
         for (i = 0; i < MAX_STREAMS_DEF; i++)
            if (head_valid[i] && (best < 0 || head_value[i] < head_value[best])) best = i;
         if (best < 0) begin
            awaiting_refill = 1'b0;
            awaited_stream = '0;
            push_out(KIND_DONE, '0, '0);
         end else begin
            head_valid[best] = 1'b0;
            awaiting_refill = 1'b1;
            awaited_stream = STREAM_BITS'(best);
            push_out(KIND_ELEM, head_value[best], STREAM_BITS'(best));
         end
      endfunction

      function void note_request(logic [OPCODE_BITS-1:0] op, logic [STREAM_BITS-1:0] s,
                                 logic signed [WORD_BITS-1:0] v);
         int lim;
         lim = stream_limit();
         if (op == OP_START) begin
            clear_merge();
            if (lim == 0) push_out(KIND_DONE, '0, '0);
         end else if (op == OP_UNUSED) begin
            push_out(KIND_ERR, '0, '0);
         end else if (awaiting_refill) begin
            if (s != awaited_stream) begin
               push_out(KIND_ERR, '0, '0);
            end else begin
               if (op == OP_OFFER) insert_head(s, v);
               emit_smallest();
            end
         end else if (fill_progress < lim) begin
            if (int'(s) != fill_progress) begin
               push_out(KIND_ERR, '0, '0);
            end else begin
               if (op == OP_OFFER) insert_head(s, v);
               fill_progress++;
               if (fill_progress == lim) emit_smallest();
            end
         end else begin
            push_out(KIND_ERR, '0, '0);
         end
      endfunction

      // stream whose answer the merge waits for, or -1 when nothing is awaited
      function int next_stream();
         if (awaiting_refill) return int'(awaited_stream);
         if (fill_progress < stream_limit()) return fill_progress;
         return -1;
      endfunction

      task report(string what);
         if (mismatches < PRINT_CAP) $display("mismatch at %0t: %s", $realtime, what);
         mismatches++;
      endtask

      task check_response(logic [KIND_BITS-1:0] kind, logic signed [WORD_BITS-1:0] val,
                          logic [STREAM_BITS-1:0] src);
         merge_word_type due;
         if (outputs_due.size() == 0) begin
            report($sformatf("unexpected word kind %0d value %0d stream %0d", kind, val, src));
            return;
         end
         due = outputs_due.pop_front();
         if (kind !== due.kind)
            report($sformatf("kind %0d, want %0d", kind, due.kind));
         if (val !== due.value)
            report($sformatf("value %0d, want %0d", val, due.value));
         if (src !== due.src)
            report($sformatf("stream %0d, want %0d", src, due.src));
      endtask
   endclass

   logic clock;
   logic reset;
   logic req_valid;
   logic req_ready;
   logic [OPCODE_BITS-1:0] req_opcode;
   logic [STREAM_BITS-1:0] req_stream;
   logic signed [WORD_BITS-1:0] req_value;
   logic rsp_valid;
   logic rsp_ready;
   logic [KIND_BITS-1:0] rsp_kind;
   logic signed [WORD_BITS-1:0] rsp_value_out;
   logic [STREAM_BITS-1:0] rsp_source_stream;
   logic psel;
   logic penable;
   logic pwrite;
   logic [ADDR_BITS-1:0] paddr;
   logic [WORD_BITS-1:0] pwdata;
   logic [WORD_BITS-1:0] prdata;
   logic pready;

   merge_tracker tracker = new();
   int words_sent = 0;
   int stall_left = 0;
   int stall_cycles = 0;
   logic tx_steady = 1'b0;
   logic rx_steady = 1'b0;
   logic hold_rx = 1'b0;
   int stream_left [MAX_STREAMS_DEF];
   longint stream_next_value [MAX_STREAMS_DEF];
   int value_step_max = 1;

   k_way_sorted_merge dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_opcode       (req_opcode),
      .req_stream       (req_stream),
      .req_value        (req_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_kind         (rsp_kind),
      .rsp_value_out    (rsp_value_out),
      .rsp_source_stream(rsp_source_stream),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready)
   );

   always #1 clock = ~clock;

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 65) return 0;
      if (roll < 95) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [COUNT_REG_BITS-1:0] pick_count();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return COUNT_REG_BITS'(1);
         2: return COUNT_REG_BITS'(MAX_STREAMS_DEF);
         3: return COUNT_REG_BITS'($urandom_range(MAX_STREAMS_DEF + 1, COUNT_MAX));
         default: return COUNT_REG_BITS'($urandom_range(2, MAX_STREAMS_DEF - 1));
      endcase
   endfunction

   task automatic send_word(logic [OPCODE_BITS-1:0] op, logic [STREAM_BITS-1:0] s,
                            logic signed [WORD_BITS-1:0] v);
      int gap;
      gap = tx_steady ? 0 : pick_gap();
      if ($urandom_range(0, 199) == 0) tx_steady = !tx_steady;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_opcode <= op;
      req_stream <= s;
      req_value  <= v;
      do @(posedge clock); while (!req_ready);
      tracker.note_request(op, s, v);
      words_sent++;
   endtask

   // drop valid right at the last accept so the word is not taken twice
   task automatic wait_results_drained();
      req_valid <= 1'b0;
      while (tracker.outputs_due.size() != 0) @(posedge clock);
   endtask

   task automatic set_streams(logic [COUNT_REG_BITS-1:0] count);
      logic [WORD_BITS-1:0] data;
      wait_results_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      data = $urandom();
      data[COUNT_REG_BITS-1:0] = count;
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= COUNT_ADDR;
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      tracker.set_stream_count(count);
      // read back through a second setup and access
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== WORD_BITS'(count))
         tracker.report($sformatf("stream count reads %0d, want %0d", prdata, count));
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic plan_streams();
      int i, style;
      style = $urandom_range(0, 3);
      case (style)
         0: value_step_max = 2;
         1: value_step_max = 1 << 28;
         2: value_step_max = 1;
         default: value_step_max = 1000;
      endcase
      for (i = 0; i < MAX_STREAMS_DEF; i++) begin
         stream_left[i] = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 7);
         case (style)
            0: stream_next_value[i] = longint'($urandom_range(0, 8)) - 4;
            1: stream_next_value[i] = longint'($signed($urandom()));
            2: stream_next_value[i] = $urandom_range(0, 1) ?
                  VALUE_MIN + longint'($urandom_range(0, 2)) :
                  VALUE_MAX - longint'($urandom_range(0, 2));
            default: stream_next_value[i] = longint'($urandom_range(0, 100000)) - 50000;
         endcase
      end
   endtask

   // One merge: mostly well-formed answers with some noise, now and then abandoned.
   task automatic run_merge();
      int s, roll;
      logic [OPCODE_BITS-1:0] op;
      logic signed [WORD_BITS-1:0] v;
      plan_streams();
      send_word(OP_START, STREAM_BITS'($urandom()), $urandom());
      forever begin
         s = tracker.next_stream();
         if (s < 0) break;
         roll = $urandom_range(0, 999);
         if (roll < 25) begin
            op = $urandom_range(0, 1) ? OP_EXHAUST : OP_OFFER;
            send_word(op, STREAM_BITS'(s + $urandom_range(1, MAX_STREAMS_DEF - 1)), $urandom());
         end else if (roll < 35) begin
            send_word(OP_UNUSED, STREAM_BITS'($urandom()), $urandom());
         end else if (roll < 38) begin
            break;
         end else begin
            if (stream_left[s] > 0) begin
               op = OP_OFFER;
               v = WORD_BITS'(stream_next_value[s]);
               stream_left[s]--;
               stream_next_value[s] = stream_next_value[s] +
                                      longint'($urandom_range(0, value_step_max));
               if (stream_next_value[s] > VALUE_MAX) stream_next_value[s] = VALUE_MAX;
            end else begin
               op = OP_EXHAUST;
               v = $urandom();
            end
            send_word(op, STREAM_BITS'(s), v);
         end
      end
      if ($urandom_range(0, 3) == 0)
         send_word($urandom_range(0, 1) ? OP_EXHAUST : OP_OFFER,
                   STREAM_BITS'($urandom()), $urandom());
   endtask

   always @(posedge clock)
      if (!reset && rsp_valid && rsp_ready)
         tracker.check_response(rsp_kind, rsp_value_out, rsp_source_stream);

   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_rx) begin
            // hold the result side long enough for the block to back up its input
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            hold_rx = 1'b0;
         end
         if ($urandom_range(0, 299) == 0) rx_steady = !rx_steady;
         if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ready <= 1'b1;
            if (!rx_steady && $urandom_range(0, 99) < 20) stall_left = pick_gap();
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (psel && penable && pready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      logic rx_held;
      logic tx_paused;
      rx_held    = 1'b0;
      tx_paused  = 1'b0;
      clock      = 1'b0;
      reset      = 1'b1;
      req_valid  = 1'b0;
      req_opcode = OP_OFFER;
      req_stream = '0;
      req_value  = '0;
      psel       = 1'b0;
      penable    = 1'b0;
      pwrite     = 1'b0;
      paddr      = '0;
      pwdata     = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // two streams out of reset, fill waits on stream 0
      send_word(OP_OFFER, 4'd1, 32'sd7);
      send_word(OP_OFFER, 4'd0, WORD_BITS'(VALUE_MAX));
      send_word(OP_OFFER, 4'd1, WORD_BITS'(VALUE_MIN));
      send_word(OP_EXHAUST, 4'd0, '0);
      send_word(OP_OFFER, 4'd1, WORD_BITS'(VALUE_MIN));
      send_word(OP_EXHAUST, 4'd1, '1);
      send_word(OP_EXHAUST, 4'd0, '0);
      send_word(OP_OFFER, 4'd15, '1);
      send_word(OP_UNUSED, 4'd15, '1);

      // equal heads leave the lower stream first
      set_streams(COUNT_REG_BITS'(3));
      send_word(OP_START, 4'd15, '1);
      send_word(OP_OFFER, 4'd0, 32'sd5);
      send_word(OP_EXHAUST, 4'd1, '0);
      send_word(OP_OFFER, 4'd2, 32'sd5);
      send_word(OP_OFFER, 4'd0, 32'sd5);
      send_word(OP_EXHAUST, 4'd0, '0);
      send_word(OP_EXHAUST, 4'd2, '0);

      set_streams('0);
      send_word(OP_START, 4'd0, '0);

      // shrink the count below the fill progress, then grow it again
      set_streams(COUNT_REG_BITS'(4));
      send_word(OP_START, 4'd0, '0);
      send_word(OP_OFFER, 4'd0, 32'sd1);
      send_word(OP_OFFER, 4'd1, 32'sd2);
      set_streams(COUNT_REG_BITS'(1));
      send_word(OP_OFFER, 4'd2, 32'sd3);
      set_streams(COUNT_REG_BITS'(3));
      send_word(OP_OFFER, 4'd2, 32'sd0);

      set_streams(COUNT_REG_BITS'(COUNT_MAX));
      while (words_sent < WORD_BUDGET) begin
         if (!rx_held && words_sent > 600) begin
            hold_rx = 1'b1;
            rx_held = 1'b1;
         end
         if (!tx_paused && words_sent > 1200) begin
            wait_results_drained();
            tx_paused = 1'b1;
         end
         if ($urandom_range(0, 2) == 0) set_streams(pick_count());
         run_merge();
      end

      wait_results_drained();
      repeat (DRAIN_TAIL) @(posedge clock);
      if (tracker.outputs_due.size() != 0)
         tracker.report($sformatf("%0d words never arrived", tracker.outputs_due.size()));
      if (tracker.mismatches == 0) $display("*** PASSED ***");
      else $display("*** FAILED ***");
      $finish;
   end

endmodule

FILE: sim.f
hw/rtl/ksm_pkg.sv
hw/rtl/ksm_cell.sv
hw/rtl/ksm_chain.sv
hw/rtl/k_way_sorted_merge.sv
tb/k_way_sorted_merge_tb.sv
